>>> sv/stake_weighted_leader_select_macros.svh
// assertion macros for the stake weighted leader select block
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef STAKE_WEIGHTED_LEADER_SELECT_MACROS_SVH
`define STAKE_WEIGHTED_LEADER_SELECT_MACROS_SVH
`ifndef SYNTHESIS
`define SWLS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SWLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SWLS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SWLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/swls_pkg.sv
// package for the stake weighted leader select block
// payload structs, controller states, command and status types, sha constants
`timescale 1ns / 1ps
package swls_pkg;

   localparam int MaxValidators = 1024;
   localparam int RankWidth     = 10;

   localparam logic [2:0] CsrSeed0 = 3'd0;
   localparam logic [2:0] CsrSeed1 = 3'd1;
   localparam logic [2:0] CsrSeed2 = 3'd2;
   localparam logic [2:0] CsrSeed3 = 3'd3;
   localparam logic [2:0] CsrRound = 3'd4;

   typedef struct packed {
      logic [63:0] key_word0;
      logic [63:0] key_word1;
      logic [63:0] key_word2;
      logic [63:0] key_word3;
      logic        has_key;
      logic [63:0] stake;
      logic        slashed;
      logic [9:0]  validator_rank;
      logic        last_in_set;
   } req_type;

   typedef struct packed {
      logic [9:0]  leader_rank;
      logic        leader_found;
      logic [63:0] leader_metric;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HASH0, ST_HASH1, ST_DIV, ST_UPDATE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;        // capture item, load block 0 schedule, init hash
      logic start_blk1;  // fold block 0, load block 1 schedule
      logic round_step;  // one compression round
      logic start_div;   // fold block 1, set up divider
      logic div_step;    // one quotient bit
      logic update;      // compare and keep best
      logic emit_clear;  // result taken, clear search
   } cmd_type;

   typedef struct packed {
      logic round_last;
      logic div_last;
      logic eligible;
      logic last_in_set;
   } sts_type;

   localparam logic [31:0] ShaK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [255:0] ShaInit = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] swap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

>>> sv/swls_ctrl.sv
// controller state machine for the stake weighted leader select block
// depends on swls_pkg; drives commands into swls_datapath
`timescale 1ns / 1ps
module swls_ctrl import swls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH0;
            end
         end
         ST_HASH0: begin
            if (!sts.eligible) begin
               state_in = sts.last_in_set ? ST_EMIT : ST_IDLE;
            end else if (sts.round_last) begin
               cmd.round_step = 1'b1;
               state_in = ST_HASH1;
            end else begin
               cmd.round_step = 1'b1;
            end
         end
         ST_HASH1: begin
            if (sts.round_last) begin
               cmd.round_step = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.round_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = sts.last_in_set ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.emit_clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // block boundary and divider setup ride on the round that ends a block
      cmd.start_blk1 = (state_ff == ST_HASH0) && sts.eligible && sts.round_last;
      cmd.start_div  = (state_ff == ST_HASH1) && sts.round_last;
   end

endmodule

>>> sv/swls_datapath.sv
// datapath: sha-256 round unit, restoring divider and best tracker
// depends on swls_pkg; commanded by swls_ctrl
`timescale 1ns / 1ps
module swls_datapath import swls_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  req_type     req_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output rsp_type     rsp_data
);

   logic [63:0]  seed_ff [4];
   logic [63:0]  round_ff;
   req_type      item_ff;
   logic [511:0] sched_ff, sched_in;
   logic [255:0] hash_ff, hash_in;
   logic [255:0] work_ff, work_in;
   logic [5:0]   rnd_ff;
   logic [6:0]   dcnt_ff;
   logic [63:0]  dq_ff, drem_ff;
   logic [63:0]  best_q_ff;
   logic [9:0]   best_rank_ff;
   logic         have_best_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff[0] <= '0;
         seed_ff[1] <= '0;
         seed_ff[2] <= '0;
         seed_ff[3] <= '0;
         round_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CsrSeed0: seed_ff[0] <= csr_data;
            CsrSeed1: seed_ff[1] <= csr_data;
            CsrSeed2: seed_ff[2] <= csr_data;
            CsrSeed3: seed_ff[3] <= csr_data;
            CsrRound: round_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // message blocks
   logic [511:0] blk0, blk1;
   assign blk0 = {seed_ff[0], seed_ff[1], seed_ff[2], seed_ff[3],
                  req_data.key_word0, req_data.key_word1,
                  req_data.key_word2, req_data.key_word3};
   assign blk1 = {swap32(round_ff[31:0]), swap32(round_ff[63:32]), 32'h80000000,
                  {12{32'h0}}, 32'd576};

   // one sha round: w[t] is the top word of the schedule window
   logic [31:0] a, b, c, d, e, f, g, h, w0, w1, w9, w14, s0, s1, wn, t1, t2;
   always_comb begin
      {a, b, c, d, e, f, g, h} = work_ff;
      w0  = sched_ff[511:480];
      w1  = sched_ff[479:448];
      w9  = sched_ff[223:192];
      w14 = sched_ff[63:32];
      s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
      s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
      wn  = w0 + s0 + w9 + s1;
      t1  = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
          + ((e & f) ^ (~e & g)) + ShaK[rnd_ff] + w0;
      t2  = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
          + ((a & b) ^ (a & c) ^ (b & c));
   end

   // fold of working vars into chaining value
   logic [255:0] folded;
   logic [255:0] rnd_out;
   logic [31:0]  na, ne;
   always_comb begin
      na = t1 + t2;
      ne = d + t1;
      rnd_out = {na, a, b, c, ne, e, f, g};
      for (int i = 0; i < 8; i++) begin
         folded[32*i +: 32] = hash_ff[32*i +: 32] + rnd_out[32*i +: 32];
      end
   end

   always_comb begin
      sched_in = sched_ff;
      work_in  = work_ff;
      hash_in  = hash_ff;
      if (cmd.load) begin
         sched_in = blk0;
         work_in  = ShaInit;
         hash_in  = ShaInit;
      end else if (cmd.start_blk1) begin
         sched_in = blk1;
         work_in  = folded;
         hash_in  = folded;
      end else if (cmd.start_div) begin
         hash_in  = folded;
      end else if (cmd.round_step) begin
         sched_in = {sched_ff[479:0], wn};
         work_in  = rnd_out;
      end
   end

   // hash registers and round counter
   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      work_ff  <= work_in;
      hash_ff  <= hash_in;
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff <= '0;
      end else if (cmd.load) begin
         rnd_ff <= '0;
      end else if (cmd.round_step) begin
         rnd_ff <= rnd_ff + 6'd1;
      end
   end

   // score from folded block 1 digest
   logic [63:0] score;
   assign score = {swap32(folded[223:192]), swap32(folded[255:224])};

   // restoring divider, one quotient bit a cycle
   logic [64:0] trial;
   assign trial = {drem_ff, dq_ff[63]} - {1'b0, item_ff.stake};
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.start_div) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 7'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         dq_ff   <= score;
         drem_ff <= '0;
      end else if (cmd.div_step) begin
         if (!trial[64]) begin
            drem_ff <= trial[63:0];
            dq_ff   <= {dq_ff[62:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[62:0], dq_ff[63]};
            dq_ff   <= {dq_ff[62:0], 1'b0};
         end
      end
   end

   // best tracker
   logic better;
   assign better = !have_best_ff || (dq_ff < best_q_ff)
                || ((dq_ff == best_q_ff) && (item_ff.validator_rank < best_rank_ff));
   always_ff @(posedge clock) begin
      if (reset || cmd.emit_clear) begin
         have_best_ff <= 1'b0;
         best_q_ff    <= '0;
         best_rank_ff <= '0;
      end else if (cmd.update && better) begin
         have_best_ff <= 1'b1;
         best_q_ff    <= dq_ff;
         best_rank_ff <= item_ff.validator_rank;
      end
   end

   assign sts.round_last  = (rnd_ff == 6'd63);
   assign sts.div_last    = (dcnt_ff == 7'd63);
   assign sts.eligible    = item_ff.has_key && !item_ff.slashed && (item_ff.stake != '0)
                         && ({1'b0, item_ff.validator_rank} < 11'(MaxValidators));
   assign sts.last_in_set = item_ff.last_in_set;

   assign rsp_data.leader_rank   = best_rank_ff;
   assign rsp_data.leader_found  = have_best_ff;
   assign rsp_data.leader_metric = best_q_ff;

endmodule

>>> sv/stake_weighted_leader_select.sv
// top level of the stake weighted leader select block
// depends on swls_pkg, swls_ctrl, swls_datapath and the assertion macro header
//
//   channel  direction  payload   transfer when
//   req      in         req_type  req_valid && !req_stall
//   rsp      out        rsp_type  rsp_valid && !rsp_stall
//   csr      in         64 bits   csr_write
//
// an eligible item goes through load, both sha blocks on the single round unit, the
// bit-per-cycle divider and the best update, and no new item is taken meanwhile
// an ineligible item is dropped in the first hash state with no round run; a last item adds the emit state
// req_stall is high while an item is in work or a result waits
// synchronous reset clears the state, the csr and counter registers and the search
`timescale 1ns / 1ps
`include "stake_weighted_leader_select_macros.svh"
module stake_weighted_leader_select import swls_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   swls_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   swls_datapath u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_data, .cmd, .sts, .rsp_data
   );

   `SWLS_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_valid, req_stall, "accept while result pending")
   `SWLS_ASSERT_NEXT(a_clear_after_emit, clock, reset, rsp_valid && !rsp_stall, !rsp_data.leader_found, "search not cleared")
   `SWLS_ASSERT_IMPL(a_found_metric, clock, reset, rsp_valid && !rsp_data.leader_found, rsp_data.leader_metric == 64'd0, "metric without leader")

endmodule

>>> test/tb.sv
// testbench for stake_weighted_leader_select: streams validator sets, predicts each election
// with an in-bench sha-256 lottery and checks every leader result; depends on swls_pkg
`timescale 1ns / 1ps
module tb;
   import swls_pkg::*;

   // election predictor and pending leader results
   class leader_board;
      logic [63:0] seed[4];
      logic [63:0] round_no;
      logic [63:0] best_q;
      logic [9:0]  best_r;
      bit          have_best;
      rsp_type     pending[$];
      int          errors;
      int          checked;

      function new();
         foreach (seed[i]) seed[i] = '0;
         round_no  = '0;
         best_q    = '0;
         best_r    = '0;
         have_best = 0;
         errors    = 0;
         checked   = 0;
      endfunction

      function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function logic [31:0] bswap(logic [31:0] x);
         return {x[7:0], x[15:8], x[23:16], x[31:24]};
      endfunction

      function void sha_block(ref logic [31:0] h[8], input logic [31:0] blk[16]);
         logic [31:0] w[64];
         logic [31:0] v[8];
         logic [31:0] t1, t2, s0, s1;
         for (int i = 0; i < 16; i++) w[i] = blk[i];
         for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         for (int i = 0; i < 8; i++) v[i] = h[i];
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ShaK[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
      endfunction

      // first 8 digest bytes of seed || key || round, read little-endian
      function logic [63:0] lottery_score(req_type r);
         logic [31:0] m0[16];
         logic [31:0] m1[16];
         logic [31:0] h[8];
         logic [63:0] keyw[4];
         keyw = '{r.key_word0, r.key_word1, r.key_word2, r.key_word3};
         for (int i = 0; i < 8; i++) h[i] = ShaInit[255 - 32*i -: 32];
         for (int i = 0; i < 4; i++) begin
            m0[2*i]     = seed[i][63:32];
            m0[2*i+1]   = seed[i][31:0];
            m0[8+2*i]   = keyw[i][63:32];
            m0[8+2*i+1] = keyw[i][31:0];
         end
         for (int i = 0; i < 16; i++) m1[i] = '0;
         m1[0]  = bswap(round_no[31:0]);
         m1[1]  = bswap(round_no[63:32]);
         m1[2]  = 32'h8000_0000;
         m1[15] = 32'd576;
         sha_block(h, m0);
         sha_block(h, m1);
         return {bswap(h[1]), bswap(h[0])};
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         if (idx < CsrRound) seed[idx] = val;
         else if (idx == CsrRound) round_no = val;
      endfunction

      function void note_validator(req_type r);
         logic [63:0] q;
         rsp_type e;
         if (r.has_key && !r.slashed && r.stake != 0 && r.validator_rank < MaxValidators) begin
            q = lottery_score(r) / r.stake;
            if (!have_best || q < best_q || (q == best_q && r.validator_rank < best_r)) begin
               best_q = q;
               best_r = r.validator_rank;
               have_best = 1;
            end
         end
         if (r.last_in_set) begin
            e.leader_rank   = have_best ? best_r : '0;
            e.leader_found  = have_best;
            e.leader_metric = have_best ? best_q : '0;
            pending = {pending, e};
            best_q = '0; best_r = '0; have_best = 0;
         end
      endfunction

      // one line per mismatch
      task report(string what, logic [63:0] want, logic [63:0] got);
         $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
         errors++;
      endtask

      task check_leader(rsp_type got);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            report("unexpected leader result", 0, got.leader_rank);
            return;
         end
         e = pending.pop_front();
         if (got.leader_rank !== e.leader_rank)
            report("leader_rank", e.leader_rank, got.leader_rank);
         if (got.leader_found !== e.leader_found)
            report("leader_found", e.leader_found, got.leader_found);
         if (got.leader_metric !== e.leader_metric)
            report("leader_metric", e.leader_metric, got.leader_metric);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   leader_board board;
   int  n_sent;
   int  n_sets;
   int  hold_cycles;
   bit  done;

   stake_weighted_leader_select u_dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // runaway guard
   initial begin
      #60ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int gap_len();
      int p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // result side: random stalls plus one long forced hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_leader(rsp_data);
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else if (done) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      board.write_reg(idx, val);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // offer one validator and wait for the transfer; valid drops only before a gap
   task automatic send_validator(req_type r, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_validator(r);
      n_sent++;
      if (r.last_in_set) n_sets++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_type random_validator(int rank, bit last, int mode);
      req_type r;
      r.key_word0 = rand64(); r.key_word1 = rand64();
      r.key_word2 = rand64(); r.key_word3 = rand64();
      r.has_key = 1; r.slashed = 0;
      case ($urandom_range(0, 3))
         0: r.stake = rand64();
         1: r.stake = 64'($urandom_range(1, 1000));
         2: r.stake = {32'h0, $urandom()} | 64'h1;
         default: r.stake = rand64() >> $urandom_range(0, 63);
      endcase
      if (r.stake == 0) r.stake = 1;
      r.validator_rank = 10'(rank);
      r.last_in_set = last;
      // noise: skipped entries
      if (mode == 1 || $urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 3))
            0: r.has_key = 0;
            1: r.slashed = 1;
            2: r.stake = 0;
            default: begin r.has_key = 1'($urandom()); r.slashed = 1'($urandom()); end
         endcase
      end
      return r;
   endfunction

   task automatic drain();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (400) @(posedge clock);
   endtask

   task automatic random_set(int len, bit gaps);
      int rank;
      bit same;
      req_type r;
      rank = $urandom_range(0, 1023 - len);
      same = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
         r = random_validator(rank + i, i == len - 1, 0);
         // occasional unordered rank
         if ($urandom_range(0, 19) == 0) r.validator_rank = 10'($urandom());
         // equal-quotient sets: same key, same stake, smaller rank arrives later
         if (same) begin
            r.key_word0 = 64'h1; r.key_word1 = 64'h2; r.key_word2 = 64'h3;
            r.key_word3 = 64'h4; r.stake = 64'hffff_ffff_ffff_ffff;
            r.validator_rank = 10'(1000 - i);
         end
         send_validator(r, gaps);
      end
   endtask

   initial begin
      req_type r;
      logic [63:0] ext[2];
      board = new();
      reset = 1; req_valid = 0; req_data = '0;
      csr_write = 0; csr_index = '0; csr_data = '0;
      hold_cycles = 0; done = 0; n_sent = 0; n_sets = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: reset registers, extremes and each skip reason
      r = '0;
      r.has_key = 1; r.stake = 64'hffff_ffff_ffff_ffff; r.validator_rank = 10'h3ff;
      send_validator(r, 0);
      r.key_word0 = '1; r.key_word1 = '1; r.key_word2 = '1; r.key_word3 = '1;
      r.stake = 1; r.validator_rank = 0;
      send_validator(r, 0);
      r.stake = 1; r.validator_rank = 5;
      send_validator(r, 0);
      r.last_in_set = 1; r.has_key = 0;
      send_validator(r, 0);
      // election with mostly skipped items
      r = random_validator(3, 0, 1); send_validator(r, 0);
      r = random_validator(4, 1, 1); send_validator(r, 0);
      // lone last item, eligible unless noise skips it
      r = random_validator(7, 1, 0); send_validator(r, 0);
      // same key and stake: later smaller rank must win the tie
      r = '0; r.has_key = 1; r.stake = 64'h2; r.key_word2 = 64'h55;
      r.validator_rank = 9; send_validator(r, 0);
      r.validator_rank = 2; send_validator(r, 0);
      r.validator_rank = 6; r.last_in_set = 1; send_validator(r, 0);
      // slashed, zero stake and no key
      r = random_validator(11, 0, 0); r.slashed = 1; send_validator(r, 0);
      r = random_validator(12, 0, 0); r.stake = 0; send_validator(r, 0);
      r = random_validator(13, 1, 0); r.has_key = 0; send_validator(r, 0);
      drain();

      // register settings: all ones, all zeros, then random phases
      ext = '{64'h0, 64'hffff_ffff_ffff_ffff};
      for (int ph = 0; ph < 8; ph++) begin
         for (int i = 0; i <= CsrRound; i++)
            write_csr(i[2:0], ph == 0 ? ext[1] : (ph == 1 ? ext[0] : rand64()));
         // unused index is ignored
         write_csr(3'd7, rand64());
         if (ph == 3) begin
            // fill up behind a long receiver hold
            hold_cycles = 2000;
            random_set(6, 0);
            random_set(3, 0);
         end
         while (n_sent < 25 + (ph + 1) * 210) random_set($urandom_range(1, 12), 1);
         // sender pauses until every result is in
         drain();
      end

      done = 1;
      drain();
      $display("ran %0d validators in %0d elections over 8 register settings",
               n_sent, n_sets);
      $display("%0d leader results checked, %0d mismatches", board.checked, board.errors);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
